// ===== rtl/sagl_pkg.sv =====
`default_nettype none
package sagl_pkg;

  localparam int unsigned SAMP_W = 16;
  localparam int unsigned GAIN_W = 26;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned GROW_W = 16;
  localparam int unsigned LVL_W  = 15;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Serial multiplier: GAIN_W x SAMP_W, one multiplier bit per cycle.
  localparam int unsigned MUL_A_W   = GAIN_W;
  localparam int unsigned MUL_B_W   = SAMP_W;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

  // Serial divider: (level << FRAC_W) / magnitude, one quotient bit per cycle.
  localparam int unsigned DIVD_W    = LVL_W + FRAC_W;
  localparam int unsigned DVS_W     = SAMP_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);

  localparam logic [GAIN_W-1:0] GAIN_MAX      = {GAIN_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_RST      = GAIN_W'(1310720);
  localparam logic [GROW_W-1:0] GROWTH_RST    = GROW_W'(26);
  localparam logic [LVL_W-1:0]  TARGET_RST    = LVL_W'(32000);
  localparam logic [LVL_W-1:0]  THRESHOLD_RST = LVL_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_GAIN    = 8'd0,
    REG_GROWTH_STEP     = 8'd1,
    REG_TARGET_LEVEL    = 8'd2,
    REG_QUIET_THRESHOLD = 8'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROW,
    ST_TEST,
    ST_DIV,
    ST_SCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sagl_if.sv =====
`default_nettype none
interface sagl_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [sagl_pkg::SAMP_W-1:0] left_in;
  logic signed [sagl_pkg::SAMP_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sagl_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [sagl_pkg::SAMP_W-1:0] left_out;
  logic signed [sagl_pkg::SAMP_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sagl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sagl_pkg::CFG_IDX_W-1:0]      index;
  logic [sagl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sagl_mul.sv =====
`default_nettype none
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
module sagl_mul (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [sagl_pkg::MUL_A_W-1:0]   a,
  input  wire logic [sagl_pkg::MUL_B_W-1:0]   b,
  output sagl_pkg::unit_stat_t                stat,
  output logic      [sagl_pkg::PROD_W-1:0]    prod
);

  localparam int unsigned AW = sagl_pkg::MUL_A_W;
  localparam int unsigned BW = sagl_pkg::MUL_B_W;

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [sagl_pkg::MUL_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sagl_pkg::PROD_W-1:0]       p_r, p_nxt;
  logic [AW-1:0]                     a_r, a_nxt;
  logic [AW:0]                       sum;

  // The upper part accumulates; the lower part holds the remaining multiplier bits.
  assign sum = {1'b0, p_r[sagl_pkg::PROD_W-1:BW]} + (p_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    a_nxt    = a_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      p_nxt    = {{AW{1'b0}}, b};
      a_nxt    = a;
    end else if (busy_r) begin
      p_nxt   = {sum, p_r[BW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sagl_pkg::MUL_CNT_W'(BW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    p_r <= p_nxt;
    a_r <= a_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = p_r;

endmodule
`default_nettype wire

// ===== rtl/sagl_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, MSB first.
module sagl_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sagl_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [sagl_pkg::DVS_W-1:0]    divisor,
  output sagl_pkg::unit_stat_t               stat,
  output logic      [sagl_pkg::DIVD_W-1:0]   quot
);

  localparam int unsigned NW = sagl_pkg::DIVD_W;
  localparam int unsigned DW = sagl_pkg::DVS_W;

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [sagl_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DW-1:0]                     rem_r, rem_nxt;
  logic [NW-1:0]                     dq_r, dq_nxt;
  logic [DW-1:0]                     dvs_r, dvs_nxt;
  logic [DW:0]                       rem_sh;
  logic [DW:0]                       diff;
  logic                              ge;

  // The dividend shifts out of the top of dq_r while quotient bits shift in below.
  assign rem_sh = {rem_r, dq_r[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      dq_nxt  = {dq_r[NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sagl_pkg::DIV_CNT_W'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = dq_r;

endmodule
`default_nettype wire

// ===== rtl/stereo_auto_gain_limiter_top.sv =====
// Each accepted beat takes three passes through the serial multiplier (growth, test,
// scale); when the gain is limited, the 31-step serial divider runs between the test
// and scale passes. A new stereo beat is taken only once the previous result beat
// has been loaded into the output register.
// Reset (rst_n low, synchronous): gain returns to 20.0, config registers to defaults.
`default_nettype none
module stereo_auto_gain_limiter_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sagl_in_if.sink     in_ch,
  sagl_out_if.source  out_ch,
  sagl_cfg_if.sink    cfg_ch
);

  localparam int unsigned SW = sagl_pkg::SAMP_W;
  localparam int unsigned GW = sagl_pkg::GAIN_W;
  localparam int unsigned FW = sagl_pkg::FRAC_W;
  localparam int unsigned PW = sagl_pkg::PROD_W;
  localparam int unsigned LW = sagl_pkg::LVL_W;

  // Configuration registers. A write to initial_gain is accepted, but since reset
  // reloads its default before the gain could ever be reloaded from it, it has no
  // visible effect and is not stored.
  logic [sagl_pkg::GROW_W-1:0] growth_r;
  logic [LW-1:0]               target_r;
  logic [LW-1:0]               thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      growth_r <= sagl_pkg::GROWTH_RST;
      target_r <= sagl_pkg::TARGET_RST;
      thr_r    <= sagl_pkg::THRESHOLD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        sagl_pkg::REG_INITIAL_GAIN:    ;
        sagl_pkg::REG_GROWTH_STEP:     growth_r <= cfg_ch.data[sagl_pkg::GROW_W-1:0];
        sagl_pkg::REG_TARGET_LEVEL:    target_r <= cfg_ch.data[LW-1:0];
        sagl_pkg::REG_QUIET_THRESHOLD: thr_r    <= cfg_ch.data[LW-1:0];
        default:                       ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Datapath registers.
  sagl_pkg::state_t state_r, state_nxt;
  logic [GW-1:0]    gain_r;
  logic [GW-1:0]    g_r;
  logic [SW-1:0]    l_mag_r;
  logic [SW-1:0]    r_mag_r;
  logic             l_neg_r;
  logic             r_neg_r;
  logic             out_valid_r;
  logic [SW-1:0]    out_l_r;
  logic [SW-1:0]    out_r_r;

  logic                                in_acc;
  logic                                out_free;
  logic [SW-1:0]                       l_abs;
  logic [SW-1:0]                       r_abs;
  logic [GW:0]                         grow_sum;
  logic [GW-1:0]                       g_grow;
  logic                                limit_hit;

  logic                                mul0_start, mul1_start, div_start;
  logic [sagl_pkg::MUL_A_W-1:0]        mul_a;
  logic [sagl_pkg::MUL_B_W-1:0]        mul0_b;
  sagl_pkg::unit_stat_t                mul0_stat, mul1_stat, div_stat;
  logic [PW-1:0]                       mul0_prod, mul1_prod;
  logic [sagl_pkg::DIVD_W-1:0]         div_q;
  logic                                out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Magnitudes of the samples; -32768 maps to 32768, which still fits in 16 bits.
  assign l_abs = in_ch.left_in[SW-1]  ? (~in_ch.left_in  + 1'b1) : in_ch.left_in;
  assign r_abs = in_ch.right_in[SW-1] ? (~in_ch.right_in + 1'b1) : in_ch.right_in;

  // Growth: gain + floor(gain * growth / 2^16), saturated to the largest gain.
  assign grow_sum = {1'b0, gain_r} + {1'b0, mul0_prod[PW-1:FW]};
  assign g_grow   = grow_sum[GW] ? sagl_pkg::GAIN_MAX : grow_sum[GW-1:0];

  // Limiting applies when the right magnitude clears the quiet threshold and the
  // grown gain times that magnitude overshoots the target level.
  assign limit_hit = (r_mag_r > {1'b0, thr_r}) &&
                     (mul0_prod > {{(PW-LW-FW){1'b0}}, target_r, {FW{1'b0}}});

  // Truncate toward zero and saturate to the signed 16-bit range.
  function automatic logic [SW-1:0] scale_sat(input logic neg,
                                              input logic [GW-1:0] mag);
    logic [GW-1:0] lim;
    lim = mag;
    if (neg) begin
      if (mag > GW'(32768)) begin
        lim = GW'(32768);
      end
      scale_sat = ~lim[SW-1:0] + 1'b1;
    end else begin
      if (mag > GW'(32767)) begin
        lim = GW'(32767);
      end
      scale_sat = lim[SW-1:0];
    end
  endfunction

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sagl_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = sagl_pkg::ST_GROW;
        end
      end
      sagl_pkg::ST_GROW: begin
        if (mul0_stat.done) begin
          state_nxt = sagl_pkg::ST_TEST;
        end
      end
      sagl_pkg::ST_TEST: begin
        if (mul0_stat.done) begin
          state_nxt = limit_hit ? sagl_pkg::ST_DIV : sagl_pkg::ST_SCALE;
        end
      end
      sagl_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = sagl_pkg::ST_SCALE;
        end
      end
      sagl_pkg::ST_SCALE: begin
        if (mul0_stat.done) begin
          state_nxt = sagl_pkg::ST_DONE;
        end
      end
      sagl_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sagl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sagl_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and operand selection. Both multipliers share operand a: in
  // the scaling pass they run in lockstep on the left and right magnitudes.
  always_comb begin
    in_ch.ready = 1'b0;
    mul0_start  = 1'b0;
    mul1_start  = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    mul_a       = g_r;
    mul0_b      = l_mag_r;
    case (state_r)
      sagl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        mul0_start  = in_acc;
        mul_a       = gain_r;
        mul0_b      = growth_r;
      end
      sagl_pkg::ST_GROW: begin
        mul0_start = mul0_stat.done;
        mul_a      = g_grow;
        mul0_b     = r_mag_r;
      end
      sagl_pkg::ST_TEST: begin
        mul0_start = mul0_stat.done && !limit_hit;
        mul1_start = mul0_stat.done && !limit_hit;
        div_start  = mul0_stat.done && limit_hit;
      end
      sagl_pkg::ST_DIV: begin
        mul0_start = div_stat.done;
        mul1_start = div_stat.done;
        mul_a      = div_q[GW-1:0];
      end
      sagl_pkg::ST_SCALE: begin
      end
      sagl_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sagl_pkg::ST_IDLE;
      gain_r      <= sagl_pkg::GAIN_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        gain_r      <= g_r;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      l_mag_r <= l_abs;
      r_mag_r <= r_abs;
      l_neg_r <= in_ch.left_in[SW-1];
      r_neg_r <= in_ch.right_in[SW-1];
    end
    if (state_r == sagl_pkg::ST_GROW && mul0_stat.done) begin
      g_r <= g_grow;
    end else if (state_r == sagl_pkg::ST_DIV && div_stat.done) begin
      g_r <= div_q[GW-1:0];
    end
    if (out_load) begin
      out_l_r <= scale_sat(l_neg_r, mul0_prod[PW-1:FW]);
      out_r_r <= scale_sat(r_neg_r, mul1_prod[PW-1:FW]);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_l_r;
  assign out_ch.right_out = out_r_r;

  sagl_mul u_mul0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul0_start),
    .a     (mul_a),
    .b     (mul0_b),
    .stat  (mul0_stat),
    .prod  (mul0_prod)
  );

  sagl_mul u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul1_start),
    .a     (mul_a),
    .b     (r_mag_r),
    .stat  (mul1_stat),
    .prod  (mul1_prod)
  );

  sagl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({target_r, {FW{1'b0}}}),
    .divisor  (r_mag_r),
    .stat     (div_stat),
    .quot     (div_q)
  );

  // Multiplier 0 is never restarted while it is still working.
  a_mul0_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    mul0_start |-> !mul0_stat.busy)
    else $error("multiplier 0 restarted while busy");

  // The two scaling multipliers finish in the same cycle.
  a_scale_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sagl_pkg::ST_SCALE) |-> (mul0_stat.done == mul1_stat.done))
    else $error("scaling multipliers out of step");

  // A limited gain is always below the grown gain it replaces.
  a_limit_lowers_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sagl_pkg::ST_DIV && div_stat.done) |->
      (div_q < {{(sagl_pkg::DIVD_W-GW){1'b0}}, g_r}))
    else $error("limited gain not below grown gain");

  // Finishing an item presents a result beat and frees the input side.
  a_done_presents: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sagl_pkg::ST_DONE && out_free) |=>
      (out_valid_r && state_r == sagl_pkg::ST_IDLE))
    else $error("finished item not presented");

endmodule
`default_nettype wire

// ===== bench/tb_stereo_auto_gain_limiter_top.sv =====
`default_nettype none
module tb_stereo_auto_gain_limiter_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped here if the bench hangs. A slow but correct run, with
  // every beat limited and both sides idling as long as they may, stays well
  // below this limit.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Number of mismatches that are printed in full; later ones are only counted.
  localparam int SHOW_LIMIT = 10;

  // One output beat as the checker expects it.
  typedef struct packed {
    logic signed [sagl_pkg::SAMP_W-1:0] left;
    logic signed [sagl_pkg::SAMP_W-1:0] right;
  } sample_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  sagl_in_if  in_bus();
  sagl_out_if out_bus();
  sagl_cfg_if cfg_bus();

  stereo_auto_gain_limiter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #1 clk = ~clk;

  // Shadow copy of the configuration registers and of the running gain.
  // The initial gain register is not mirrored: the block is reset once, so
  // a write to it never reaches the running gain.
  logic [sagl_pkg::GROW_W-1:0] growth_q;
  logic [sagl_pkg::LVL_W-1:0]  target_q;
  logic [sagl_pkg::LVL_W-1:0]  quiet_q;
  logic [sagl_pkg::GAIN_W-1:0] gain_q;

  sample_pair_t expected_q[$];

  int  mismatch_count = 0;
  int  result_count = 0;
  int  cycle_count = 0;
  bit  idle_enable = 1'b1;
  int  sink_hold_cycles = 0;

  // Watchdog: a hang or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Multiplies one sample by the gain, truncating toward zero, and clamps the
  // result into the signed 16-bit range.
  function automatic logic signed [sagl_pkg::SAMP_W-1:0] scale_clip(
      input logic signed [sagl_pkg::SAMP_W-1:0] s,
      input logic [sagl_pkg::GAIN_W-1:0] g);
    longint mag;
    longint p;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    p = (mag * longint'(g)) >>> sagl_pkg::FRAC_W;
    if (s < 0) begin
      if (p > 32768) p = 32768;
      return sagl_pkg::SAMP_W'(-p);
    end
    if (p > 32767) p = 32767;
    return sagl_pkg::SAMP_W'(p);
  endfunction

  // Advances the shadow gain by one stereo pair and returns the expected beat.
  // The gain grows first and saturates; then, if the right channel is loud
  // enough and would overshoot the target, the gain is cut to target / |right|.
  function automatic sample_pair_t apply_agc(input logic signed [sagl_pkg::SAMP_W-1:0] l,
                                             input logic signed [sagl_pkg::SAMP_W-1:0] r);
    longint g;
    longint mag;
    longint ceiling;
    sample_pair_t res;
    mag = (r < 0) ? -longint'(r) : longint'(r);
    ceiling = longint'(target_q) << sagl_pkg::FRAC_W;
    g = longint'(gain_q);
    g = g + ((g * longint'(growth_q)) >>> sagl_pkg::FRAC_W);
    if (g > longint'(sagl_pkg::GAIN_MAX)) g = longint'(sagl_pkg::GAIN_MAX);
    // The threshold is never negative, so a limited step always divides by
    // at least one.
    if (mag > longint'(quiet_q) && g * mag > ceiling) g = ceiling / mag;
    gain_q = g[sagl_pkg::GAIN_W-1:0];
    res.left = scale_clip(l, gain_q);
    res.right = scale_clip(r, gain_q);
    return res;
  endfunction

  // Idle cycles before the next beat on either side; zero in a burst stretch.
  function automatic int draw_wait();
    return idle_enable ? int'($urandom_range(0, 19)) : 0;
  endfunction

  // Sample values: half of them full range, with clusters near zero, at the rails
  // and right around the quiet threshold, where limiting switches on and off.
  function automatic logic signed [sagl_pkg::SAMP_W-1:0] pick_sample();
    int v;
    v = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom());
      5, 6: v = int'($urandom_range(0, 400)) - 200;
      7: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          default: v = 0;
        endcase
      end
      default: begin
        v = int'(quiet_q) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return sagl_pkg::SAMP_W'(v);
  endfunction

  // Records one failure; only the first few are printed.
  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT) $display("%s", msg);
  endtask

  // Sends one stereo pair. It is entered and left at a rising edge; valid is
  // lowered only when a gap follows, so back-to-back beats keep it high.
  task automatic send_pair(input logic signed [sagl_pkg::SAMP_W-1:0] l,
                           input logic signed [sagl_pkg::SAMP_W-1:0] r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.left_in <= l;
    in_bus.right_in <= r;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    // The beat was taken at this edge, so the gain moves on now.
    expected_q.push_back(apply_agc(l, r));
  endtask

  // Writes one configuration register and mirrors the write in the shadow
  // copy. Indexes above the last register must leave everything unchanged.
  task automatic write_reg(input logic [sagl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sagl_pkg::CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    case (idx)
      sagl_pkg::REG_INITIAL_GAIN:    ;
      sagl_pkg::REG_GROWTH_STEP:     growth_q = value[sagl_pkg::GROW_W-1:0];
      sagl_pkg::REG_TARGET_LEVEL:    target_q = value[sagl_pkg::LVL_W-1:0];
      sagl_pkg::REG_QUIET_THRESHOLD: quiet_q = value[sagl_pkg::LVL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stops offering beats and waits until every expected beat has come back,
  // so the block is idle before the registers change.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side: draws its own stall before each beat, honors a long hold
  // request from the tests, and checks every beat against the oldest
  // expectation, one field at a time.
  initial begin : result_checker
    sample_pair_t want;
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      result_count++;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("beat %0d arrived with nothing expected: left %0d right %0d",
                               result_count, out_bus.left_out, out_bus.right_out));
      end else begin
        want = expected_q.pop_front();
        if (out_bus.left_out !== want.left)
          note_failure($sformatf("beat %0d left_out: expected %0d, got %0d",
                                 result_count, want.left, out_bus.left_out));
        if (out_bus.right_out !== want.right)
          note_failure($sformatf("beat %0d right_out: expected %0d, got %0d",
                                 result_count, want.right, out_bus.right_out));
      end
    end
  end

  // Default registers: rails on both channels, tiny values, the threshold
  // edges on the right channel, and the left channel at both rails while the
  // right channel is silent.
  task automatic test_directed_extremes();
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(16'sd1, -16'sd1);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd0, 16'sd60);
    send_pair(16'sd0, -16'sd60);
    // Just above the threshold; the gain left by the rails is too low to be cut here.
    send_pair(16'sd0, 16'sd61);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(-16'sd32767, 16'sd0);
    send_pair(16'sd0, -16'sd61);
    send_pair(16'sd100, -16'sd100);
    wait_for_results();
  endtask

  // Register extremes: the fastest growth with limiting disabled nearly doubles
  // the gain on each beat; the loudest right sample still gets limited.
  // Also covers masking of wide write data and an index past the last
  // register.
  task automatic test_register_extremes();
    write_reg(sagl_pkg::REG_INITIAL_GAIN, 32'hFFFF_FFFF);
    write_reg(sagl_pkg::REG_GROWTH_STEP, 32'hABCD_FFFF);
    write_reg(sagl_pkg::REG_TARGET_LEVEL, 32'd32767);
    write_reg(sagl_pkg::REG_QUIET_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(sagl_pkg::CFG_IDX_W'(4), 32'd0);
    write_reg(sagl_pkg::CFG_IDX_W'(255), 32'd0);
    repeat (6) send_pair(16'sd1000, 16'sd0);
    send_pair(16'sd32767, -16'sd32767);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd5, -16'sd32768);
    send_pair(-16'sd5, 16'sd32767);
    wait_for_results();
    write_reg(sagl_pkg::REG_INITIAL_GAIN, 32'd0);
  endtask

  // The result side holds off for a long stretch while the input side keeps
  // offering beats in a burst, so the block fills up and stalls its input.
  task automatic test_output_backpressure();
    write_reg(sagl_pkg::REG_GROWTH_STEP, 32'd26);
    write_reg(sagl_pkg::REG_TARGET_LEVEL, 32'd32000);
    write_reg(sagl_pkg::REG_QUIET_THRESHOLD, 32'd60);
    idle_enable = 1'b0;
    sink_hold_cycles = 600;
    repeat (30) send_pair(pick_sample(), pick_sample());
    idle_enable = 1'b1;
    wait_for_results();
  endtask

  // Random phases, each with a fresh set of registers. If an earlier phase
  // left the gain very low, a short burst with fast growth and no limiting
  // lifts it back up first, so later phases still see the whole gain range.
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      if (gain_q < sagl_pkg::GAIN_W'(1024)) begin
        write_reg(sagl_pkg::REG_GROWTH_STEP, 32'd65535);
        write_reg(sagl_pkg::REG_QUIET_THRESHOLD, 32'd32767);
        repeat (30) send_pair(pick_sample(), sagl_pkg::SAMP_W'($urandom_range(0, 32767)));
        wait_for_results();
      end
      write_reg(sagl_pkg::REG_INITIAL_GAIN, (phase == 1) ? 32'd0 : $urandom());
      case ($urandom_range(0, 3))
        0: write_reg(sagl_pkg::REG_GROWTH_STEP, 32'd0);
        1: write_reg(sagl_pkg::REG_GROWTH_STEP, 32'd65535);
        2: write_reg(sagl_pkg::REG_GROWTH_STEP, $urandom_range(0, 64));
        default: write_reg(sagl_pkg::REG_GROWTH_STEP, $urandom());
      endcase
      // A target of zero would pin the gain at zero for good, so it is left
      // to the last test.
      case ($urandom_range(0, 3))
        0: write_reg(sagl_pkg::REG_TARGET_LEVEL, 32'd1);
        1: write_reg(sagl_pkg::REG_TARGET_LEVEL, 32'd32767);
        default: write_reg(sagl_pkg::REG_TARGET_LEVEL, $urandom_range(1, 32767));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(sagl_pkg::REG_QUIET_THRESHOLD, 32'd0);
        1: write_reg(sagl_pkg::REG_QUIET_THRESHOLD, 32'd32767);
        2: write_reg(sagl_pkg::REG_QUIET_THRESHOLD, $urandom_range(0, 200));
        default: write_reg(sagl_pkg::REG_QUIET_THRESHOLD, $urandom());
      endcase
      if ($urandom_range(0, 1) == 1)
        write_reg(sagl_pkg::CFG_IDX_W'($urandom_range(4, 255)), $urandom());
      // One phase runs as a burst with no idling on either side.
      idle_enable = (phase != 3);
      repeat (160) send_pair(pick_sample(), pick_sample());
      idle_enable = 1'b1;
      wait_for_results();
    end
  endtask

  // Zero gain: a target of zero with a zero threshold cuts the gain to zero
  // on the first non-silent right sample, and no growth can revive it.
  task automatic test_zero_gain();
    write_reg(sagl_pkg::REG_TARGET_LEVEL, 32'd0);
    write_reg(sagl_pkg::REG_QUIET_THRESHOLD, 32'd0);
    send_pair(16'sd100, 16'sd5);
    repeat (5) send_pair(pick_sample(), pick_sample());
    wait_for_results();
    write_reg(sagl_pkg::REG_GROWTH_STEP, 32'd65535);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
    repeat (4) send_pair(pick_sample(), pick_sample());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.left_in <= '0;
    in_bus.right_in <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    growth_q = sagl_pkg::GROWTH_RST;
    target_q = sagl_pkg::TARGET_RST;
    quiet_q = sagl_pkg::THRESHOLD_RST;
    gain_q = sagl_pkg::GAIN_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_register_extremes();
    test_output_backpressure();
    test_random_phases();
    test_zero_gain();

    // Let every outstanding beat return, then watch a little longer for
    // stray beats before the verdict.
    wait_for_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
